>>> rtl/core/efg_pkg.sv
package efg_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int MAX_IDS        = 16;

  localparam int KIND_W   = 3;
  localparam int TASK_W   = 4;
  localparam int PRIO_W   = 8;
  localparam int FLAG_W   = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_WAIT   = 3'd0,
    KIND_SET    = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_CANCEL = 3'd3,
    KIND_READ   = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_TIMEOUT     = 3'd1,
    STAT_INVALID     = 3'd2,
    STAT_QUEUED      = 3'd3,
    STAT_WOKEN       = 3'd4,
    STAT_NOT_WAITING = 3'd5
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_EVAL,
    CELL_SCAN
  } cell_op_t;

  typedef struct packed {
    logic [FLAG_W-1:0] mask;
    logic [PRIO_W-1:0] prio;
    logic [TASK_W-1:0] task_no;
    logic              match_all;
    logic              coe;
  } waiter_t;

  typedef struct packed {
    cell_op_t          op;
    waiter_t           req;
    logic [FLAG_W-1:0] flags;
  } cell_ctl_t;

  function automatic logic cond_met(input logic [FLAG_W-1:0] flags,
                                    input logic [FLAG_W-1:0] want,
                                    input logic              all_bits);
    logic [FLAG_W-1:0] hit;
    hit = flags & want;
    return all_bits ? (hit == want) : (hit != '0);
  endfunction

endpackage

>>> rtl/core/event_flag_group_engine.sv
// Wait, clear, cancel, read and a set that wakes nobody finish in the accept cycle;
// the result beat is presented the next cycle, and while the output is not stalled
// one such item per cycle is taken. A set that wakes waiters scans the N entries queued
// at the set: the head cell is examined once per cycle while the chain shifts toward
// the head. Output stalls stretch that scan only on cycles that must emit a woken beat.
// Synchronous rst clears the flags, the waiter count and control; queue cells are not reset.
module event_flag_group_engine import efg_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [TASK_W-1:0]   task_id,
  input  logic [PRIO_W-1:0]   priority_req,
  input  logic [FLAG_W-1:0]   mask,
  input  logic                match_all,
  input  logic                clear_on_wake,
  input  logic                no_wait,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [TASK_W-1:0]   woken_task,
  output logic [FLAG_W-1:0]   flags_snapshot,
  output logic                last
);

  // The queue never holds more entries than there are distinct task slots.
  localparam int QueueDepth = (TASK_SLOTS < MAX_IDS) ? TASK_SLOTS : MAX_IDS;
  localparam int CntW       = $clog2(QueueDepth + 1);

  state_t            state;
  state_t            state_next;
  logic [FLAG_W-1:0] flags;
  logic [FLAG_W-1:0] flags_next;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   count_next;
  // Entries of the wake scan not yet looked at.
  logic [CntW-1:0]   rem;
  logic [CntW-1:0]   rem_next;
  // Clear-on-exit bits collected during a scan, applied when it ends.
  logic [FLAG_W-1:0] deferred;
  logic [FLAG_W-1:0] deferred_next;

  cell_op_t          cell_op;
  cell_ctl_t         cell_ctl;
  waiter_t           cell_entry [QueueDepth];
  logic [QueueDepth-1:0] cell_met;
  logic [QueueDepth-1:0] cell_met_now;
  logic [QueueDepth-1:0] cell_keep;
  logic [QueueDepth-1:0] cell_hit;

  logic              accept;
  logic              out_free;
  logic              out_load;
  status_t           load_status;
  logic [TASK_W-1:0] load_task;
  logic [FLAG_W-1:0] load_snap;
  logic              load_last;

  logic              any_met;
  logic              found;
  logic              head_met;
  logic              scan_step;
  logic              scan_end;
  logic              is_set;
  logic              too_big;
  logic              full;
  logic [FLAG_W-1:0] flags_set;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign is_set    = (kind_t'(kind) == KIND_SET);
  assign flags_set = flags | mask;
  assign any_met   = |cell_met_now;
  assign found     = cell_hit[QueueDepth-1];
  assign head_met  = cell_met[0];
  assign too_big   = int'(task_id) >= QueueDepth;
  assign full      = count >= CntW'(QueueDepth);
  // A head entry that wakes needs the output register; one that stays does not.
  assign scan_step = (state == ST_SCAN) && (!head_met || out_free);
  assign scan_end  = scan_step && (rem == CntW'(1));

  assign cell_ctl.op    = cell_op;
  assign cell_ctl.req   = '{mask: mask, prio: priority_req, task_no: task_id,
                            match_all: match_all, coe: clear_on_wake};
  assign cell_ctl.flags = flags_set;

  // The queue: cells kept in priority order, FIFO among equal priorities.
  // The priority compare (keep) and the task match chain (hit) run cell to cell.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    waiter_t left_e;
    waiter_t right_e;
    logic    left_k;
    logic    right_m;
    logic    hit_i;
    logic    occ;
    logic    tail_wr;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_k = 1'b1;
      assign hit_i  = 1'b0;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_k = cell_keep[i-1];
      assign hit_i  = cell_hit[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_e = '0;
      assign right_m = 1'b0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
      assign right_m = cell_met[i+1];
    end

    assign occ = CntW'(i) < count;
    // A head entry that stays asleep goes back in at the end of the queue.
    assign tail_wr = (count == CntW'(i + 1)) && !head_met;

    efg_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .occ         (occ),
      .left_entry  (left_e),
      .left_keep   (left_k),
      .right_entry (right_e),
      .right_met   (right_m),
      .hit_in      (hit_i),
      .tail_wr     (tail_wr),
      .head_entry  (cell_entry[0]),
      .entry       (cell_entry[i]),
      .met         (cell_met[i]),
      .met_now     (cell_met_now[i]),
      .keep        (cell_keep[i]),
      .hit_out     (cell_hit[i])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_set && any_met) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Item decode, queue commands and result beats.
  always_comb begin
    cell_op       = CELL_HOLD;
    out_load      = 1'b0;
    load_status   = STAT_OK;
    load_task     = '0;
    load_snap     = flags;
    load_last     = 1'b1;
    flags_next    = flags;
    count_next    = count;
    rem_next      = rem;
    deferred_next = deferred;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_t'(kind))
            KIND_WAIT: begin
              out_load  = 1'b1;
              load_task = task_id;
              if (mask == '0) begin
                load_status = STAT_INVALID;
              end else if (cond_met(flags, mask, match_all)) begin
                load_status = STAT_OK;
                if (clear_on_wake) begin
                  flags_next = flags & ~mask;
                end
              end else if (no_wait) begin
                load_status = STAT_TIMEOUT;
              end else if (too_big || found || full) begin
                load_status = STAT_INVALID;
              end else begin
                load_status = STAT_QUEUED;
                cell_op     = CELL_INSERT;
                count_next  = count + 1'b1;
              end
            end
            KIND_SET: begin
              flags_next = flags_set;
              cell_op    = CELL_EVAL;
              if (any_met) begin
                rem_next      = count;
                deferred_next = '0;
              end else begin
                out_load  = 1'b1;
                load_snap = flags_set;
              end
            end
            KIND_CLEAR: begin
              flags_next = flags & ~mask;
              out_load   = 1'b1;
              load_snap  = flags & ~mask;
            end
            KIND_CANCEL: begin
              out_load  = 1'b1;
              load_task = task_id;
              if (found) begin
                load_status = STAT_TIMEOUT;
                cell_op     = CELL_REMOVE;
                count_next  = count - 1'b1;
              end else begin
                load_status = STAT_NOT_WAITING;
              end
            end
            KIND_READ: begin
              out_load = 1'b1;
            end
            default: begin
              out_load    = 1'b1;
              load_status = STAT_INVALID;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_step) begin
          cell_op  = CELL_SCAN;
          rem_next = rem - 1'b1;
          if (head_met) begin
            out_load    = 1'b1;
            load_status = STAT_WOKEN;
            load_task   = cell_entry[0].task_no;
            // Last woken beat when no later entry is marked to wake.
            load_last   = !(|cell_met[QueueDepth-1:1]);
            count_next  = count - 1'b1;
            if (cell_entry[0].coe) begin
              deferred_next = deferred | cell_entry[0].mask;
            end
          end
          if (rem == CntW'(1)) begin
            flags_next = flags & ~deferred_next;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flags     <= '0;
      count     <= '0;
      rem       <= '0;
      deferred  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      flags    <= flags_next;
      count    <= count_next;
      rem      <= rem_next;
      deferred <= deferred_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status         <= load_status;
      woken_task     <= load_task;
      flags_snapshot <= load_snap;
      last           <= load_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QueueDepth))
    else $error("waiter count exceeds queue depth");

  a_scan_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rem != '0) && (rem <= count))
    else $error("wake scan position outside the queue");

  a_wake_pops: assert property (@(posedge clk) disable iff (rst)
    (scan_step && head_met) |=> (count == $past(count) - 1'b1))
    else $error("woken waiter not removed from the queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result beat overwrites a pending beat");

endmodule

>>> rtl/core/efg_cell.sv
// One queue slot. Entries move one cell toward the tail on an insert and one
// cell toward the head on a removal or a wake scan step.
module efg_cell import efg_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occ,
  input  waiter_t   left_entry,
  input  logic      left_keep,
  input  waiter_t   right_entry,
  input  logic      right_met,
  input  logic      hit_in,
  input  logic      tail_wr,
  input  waiter_t   head_entry,
  output waiter_t   entry,
  output logic      met,
  output logic      met_now,
  output logic      keep,
  output logic      hit_out
);

  logic match;

  assign keep    = occ && (entry.prio >= ctl.req.prio);
  assign match   = occ && (entry.task_no == ctl.req.task_no);
  assign hit_out = hit_in || match;
  assign met_now = occ && cond_met(ctl.flags, entry.mask, entry.match_all);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_INSERT: begin
        if (!keep) begin
          entry <= left_keep ? ctl.req : left_entry;
        end
      end
      CELL_REMOVE: begin
        if (hit_out) begin
          entry <= right_entry;
        end
      end
      CELL_EVAL: begin
        met <= met_now;
      end
      CELL_SCAN: begin
        if (tail_wr) begin
          entry <= head_entry;
          met   <= 1'b0;
        end else begin
          entry <= right_entry;
          met   <= right_met;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
